@@ src/point_in_polygon_test_defines.svh @@
// assertion macros used by the checker
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PIP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PIP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/pip_pkg.sv @@
package pip_pkg;

	localparam int FIELD_WIDTH = 16;
	localparam int COORD_WIDTH = 16;
	localparam int EXT_WIDTH   = (COORD_WIDTH > FIELD_WIDTH) ? COORD_WIDTH : FIELD_WIDTH;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
	localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
	localparam int SUM_WIDTH   = PROD_WIDTH + 1;

	localparam logic [1:0] VERDICT_OUT = 2'd0;
	localparam logic [1:0] VERDICT_ON  = 2'd1;
	localparam logic [1:0] VERDICT_IN  = 2'd2;

	typedef logic [FIELD_WIDTH-1:0]        field_t;
	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [SUM_WIDTH-1:0]   sum_t;

	// edge ends relative to the query point, lower end first
	typedef struct packed {
		diff_t ax;
		diff_t ay;
		diff_t bx;
		diff_t by;
	} edge_t;

	// partial products of cross and dot product, plus the span flags
	typedef struct packed {
		prod_t axby;
		prod_t aybx;
		prod_t axbx;
		prod_t ayby;
		logic  low_le0;
		logic  up_gt0;
	} prods_t;

	typedef struct packed {
		logic toggle;
		logic touch;
	} hit_t;

	// low COORD_WIDTH bits of a field, read as a signed coordinate
	function automatic coord_t to_coord(input field_t f);
		logic [EXT_WIDTH-1:0] t;
		t = EXT_WIDTH'(f);
		return coord_t'(t[COORD_WIDTH-1:0]);
	endfunction

endpackage

@@ src/pip_edge_order.sv @@
module pip_edge_order (
	input  pip_pkg::coord_t ux,
	input  pip_pkg::coord_t uy,
	input  pip_pkg::coord_t vx,
	input  pip_pkg::coord_t vy,
	input  pip_pkg::coord_t px,
	input  pip_pkg::coord_t py,
	output pip_pkg::edge_t  edge_o
);

	pip_pkg::diff_t rux, ruy, rvx, rvy;

	always_comb begin
		rux = pip_pkg::diff_t'(ux) - pip_pkg::diff_t'(px);
		ruy = pip_pkg::diff_t'(uy) - pip_pkg::diff_t'(py);
		rvx = pip_pkg::diff_t'(vx) - pip_pkg::diff_t'(px);
		rvy = pip_pkg::diff_t'(vy) - pip_pkg::diff_t'(py);
		// put the end with the smaller y first
		if (ruy > rvy) begin
			edge_o = '{ax: rvx, ay: rvy, bx: rux, by: ruy};
		end else begin
			edge_o = '{ax: rux, ay: ruy, bx: rvx, by: rvy};
		end
	end

endmodule

@@ src/pip_edge_mul.sv @@
module pip_edge_mul (
	input  pip_pkg::edge_t  edge_i,
	output pip_pkg::prods_t prods
);

	always_comb begin
		prods.axby    = edge_i.ax * edge_i.by;
		prods.aybx    = edge_i.ay * edge_i.bx;
		prods.axbx    = edge_i.ax * edge_i.bx;
		prods.ayby    = edge_i.ay * edge_i.by;
		prods.low_le0 = (edge_i.ay <= pip_pkg::diff_t'(0));
		prods.up_gt0  = (edge_i.by > pip_pkg::diff_t'(0));
	end

endmodule

@@ src/pip_edge_test.sv @@
module pip_edge_test (
	input  pip_pkg::prods_t prods,
	output pip_pkg::hit_t   hit
);

	pip_pkg::sum_t cr, dt;

	always_comb begin
		cr = pip_pkg::sum_t'(prods.axby) - pip_pkg::sum_t'(prods.aybx);
		dt = pip_pkg::sum_t'(prods.axbx) + pip_pkg::sum_t'(prods.ayby);
		// half-open crossing with the point to the right of the edge
		hit.toggle = prods.low_le0 && prods.up_gt0 && (cr < pip_pkg::sum_t'(0));
		// collinear and between the ends
		hit.touch  = (cr == pip_pkg::sum_t'(0)) && (dt <= pip_pkg::sum_t'(0));
	end

endmodule

@@ src/point_in_polygon_test.sv @@
// point in polygon by crossing number, one vertex item per cycle while no stalled verdict holds the pipeline
// a verdict shows on out_valid after its last vertex passes stages 1, 2 and 3 into the result register
// the edge pipeline has three stages (order, multiply, test)
// in_stall rises only when the verdict register is full and stalled, every stage is full
// and stage 3 holds a last vertex
// reset (arst_n low, asynchronous): pipeline emptied, held vertices, query point and flags zero
module point_in_polygon_test (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  pip_pkg::field_t vertex_x,
	input  pip_pkg::field_t vertex_y,
	input  pip_pkg::field_t query_x,
	input  pip_pkg::field_t query_y,
	input  logic            first,
	input  logic            last,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      verdict
);

	// held polygon state, updated as each vertex item is accepted
	pip_pkg::coord_t start_x_q, start_y_q;
	pip_pkg::coord_t prev_x_q, prev_y_q;
	pip_pkg::coord_t point_x_q, point_y_q;
	logic            parity_q;
	logic            on_edge_q;

	// stage 1: raw vertex with its neighbors and the query point
	logic            valid_s1;
	pip_pkg::coord_t vx_s1, vy_s1, ux_s1, uy_s1, sx_s1, sy_s1, px_s1, py_s1;
	logic            first_s1, last_s1;

	// stage 2: both edges relative to the point and ordered by y
	logic            valid_s2;
	pip_pkg::edge_t  open_s2, close_s2;
	logic            first_s2, last_s2;

	// stage 3: products of both edges
	logic            valid_s3;
	pip_pkg::prods_t open_s3, close_s3;
	logic            first_s3, last_s3;

	// result register
	logic            out_valid_q;
	logic [1:0]      verdict_q;

	// combinational
	pip_pkg::coord_t vx_in, vy_in, qx_in, qy_in;
	pip_pkg::edge_t  open_edge, close_edge;
	pip_pkg::prods_t open_prods, close_prods;
	pip_pkg::hit_t   open_hit, close_hit;
	logic            out_free, rdy_s1, rdy_s2, rdy_s3, take_in, done_s3;
	logic            par_base, on_base, par_mid, on_mid, par_end, on_end;

	assign vx_in = pip_pkg::to_coord(vertex_x);
	assign vy_in = pip_pkg::to_coord(vertex_y);
	assign qx_in = pip_pkg::to_coord(query_x);
	assign qy_in = pip_pkg::to_coord(query_y);

	// each stage moves when the one after it is empty or moving; a non-last
	// item leaves stage 3 without needing the result register
	assign out_free = !out_valid_q || !out_stall;
	assign rdy_s3   = !valid_s3 || !last_s3 || out_free;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign take_in  = in_valid && rdy_s1;
	assign done_s3  = valid_s3 && rdy_s3;
	assign in_stall = !rdy_s1;

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

	// held state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q   <= '0;
			start_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			point_x_q   <= '0;
			point_y_q   <= '0;
			parity_q    <= 1'b0;
			on_edge_q   <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_in) begin
				prev_x_q <= vx_in;
				prev_y_q <= vy_in;
				if (first) begin
					start_x_q <= vx_in;
					start_y_q <= vy_in;
					point_x_q <= qx_in;
					point_y_q <= qy_in;
				end
			end
			if (rdy_s1) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			// flags accumulate as items leave stage 3, in order
			if (done_s3) begin
				parity_q  <= par_end;
				on_edge_q <= on_end;
			end
			if (done_s3 && last_s3) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			vx_s1    <= vx_in;
			vy_s1    <= vy_in;
			ux_s1    <= prev_x_q;
			uy_s1    <= prev_y_q;
			sx_s1    <= first ? vx_in : start_x_q;
			sy_s1    <= first ? vy_in : start_y_q;
			px_s1    <= first ? qx_in : point_x_q;
			py_s1    <= first ? qy_in : point_y_q;
			first_s1 <= first;
			last_s1  <= last;
		end
		if (rdy_s2 && valid_s1) begin
			open_s2  <= open_edge;
			close_s2 <= close_edge;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
		if (rdy_s3 && valid_s2) begin
			open_s3  <= open_prods;
			close_s3 <= close_prods;
			first_s3 <= first_s2;
			last_s3  <= last_s2;
		end
		if (done_s3 && last_s3) begin
			if (on_end) begin
				verdict_q <= pip_pkg::VERDICT_ON;
			end else if (par_end) begin
				verdict_q <= pip_pkg::VERDICT_IN;
			end else begin
				verdict_q <= pip_pkg::VERDICT_OUT;
			end
		end
	end

	// edge from the previous vertex to this one
	pip_edge_order u_open_order (
		.ux     (ux_s1),
		.uy     (uy_s1),
		.vx     (vx_s1),
		.vy     (vy_s1),
		.px     (px_s1),
		.py     (py_s1),
		.edge_o (open_edge)
	);

	// closing edge from this vertex back to the first one
	pip_edge_order u_close_order (
		.ux     (vx_s1),
		.uy     (vy_s1),
		.vx     (sx_s1),
		.vy     (sy_s1),
		.px     (px_s1),
		.py     (py_s1),
		.edge_o (close_edge)
	);

	pip_edge_mul u_open_mul (
		.edge_i (open_s2),
		.prods  (open_prods)
	);

	pip_edge_mul u_close_mul (
		.edge_i (close_s2),
		.prods  (close_prods)
	);

	pip_edge_test u_open_test (
		.prods (open_s3),
		.hit   (open_hit)
	);

	pip_edge_test u_close_test (
		.prods (close_s3),
		.hit   (close_hit)
	);

	// a first vertex restarts the flags and has no opening edge;
	// only a last vertex tests the closing edge
	always_comb begin
		par_base = first_s3 ? 1'b0 : parity_q;
		on_base  = first_s3 ? 1'b0 : on_edge_q;
		par_mid  = par_base ^ (!first_s3 && open_hit.toggle);
		on_mid   = on_base | (!first_s3 && open_hit.touch);
		par_end  = par_mid ^ (last_s3 && close_hit.toggle);
		on_end   = on_mid | (last_s3 && close_hit.touch);
	end

endmodule

@@ src/pip_checker.sv @@
`include "point_in_polygon_test_defines.svh"

module pip_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input pip_pkg::field_t vertex_x,
	input pip_pkg::field_t vertex_y,
	input pip_pkg::field_t query_x,
	input pip_pkg::field_t query_y,
	input logic            first,
	input logic            last,
	input logic            out_valid,
	input logic            out_stall,
	input logic [1:0]      verdict
);

	logic [4*pip_pkg::FIELD_WIDTH+1:0] in_item;
	logic                              verdict_legal;

	assign in_item       = {vertex_x, vertex_y, query_x, query_y, first, last};
	assign verdict_legal = (verdict == pip_pkg::VERDICT_OUT) ||
		(verdict == pip_pkg::VERDICT_ON) || (verdict == pip_pkg::VERDICT_IN);

	// a verdict held back stays put
	`PIP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(verdict), "verdict changed while stalled")

	// only the three verdict codes come out
	`PIP_ASSERT_NOW(a_verdict_code, out_valid, verdict_legal, "illegal verdict code")

	// input back-pressure only comes from a stalled, waiting verdict
	`PIP_ASSERT_NOW(a_stall_source, !out_valid || !out_stall, !in_stall, "input stalled with free result register")

	// a stalled vertex item is held by the sender
	`PIP_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_item), "vertex item changed while stalled")

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.vertex_x  (vertex_x),
	.vertex_y  (vertex_y),
	.query_x   (query_x),
	.query_y   (query_y),
	.first     (first),
	.last      (last),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.verdict   (verdict)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	// receiver hold-off that forces the block to fill and stall its input
	localparam int unsigned HOLD_CYCLES    = 300;
	// cycles with no item moving on either side before the run is called dead
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	// item count, directed part included, up to which random polygons are sent
	localparam int unsigned RANDOM_ITEMS   = 800;
	// cycles to let pass after the last verdict, a few times the pipeline depth
	localparam int unsigned DRAIN_CYCLES   = 12;

	// crossing-number tracker: own copy of the polygon state, predicts each verdict
	class crossing_board;
		pip_pkg::coord_t start_x, start_y;
		pip_pkg::coord_t prev_x, prev_y;
		pip_pkg::coord_t point_x, point_y;
		bit              parity;
		bit              on_edge;
		logic [1:0]      verdicts_due[$];
		int              errors;

		function new();
			start_x = '0;
			start_y = '0;
			prev_x  = '0;
			prev_y  = '0;
			point_x = '0;
			point_y = '0;
			parity  = 1'b0;
			on_edge = 1'b0;
			errors  = 0;
		endfunction

		// low COORD_WIDTH bits, read as a signed coordinate
		function pip_pkg::coord_t field_coord(pip_pkg::field_t f);
			pip_pkg::coord_t c;
			c = f[pip_pkg::COORD_WIDTH-1:0];
			return c;
		endfunction

		// one edge, both ends relative to the query point, lower end first
		function void cross_edge(pip_pkg::coord_t ux, pip_pkg::coord_t uy,
				pip_pkg::coord_t vx, pip_pkg::coord_t vy);
			longint ax, ay, bx, by, t, cr, dt;
			ax = longint'(ux) - longint'(point_x);
			ay = longint'(uy) - longint'(point_y);
			bx = longint'(vx) - longint'(point_x);
			by = longint'(vy) - longint'(point_y);
			if (ay > by) begin
				t = ax; ax = bx; bx = t;
				t = ay; ay = by; by = t;
			end
			cr = ax * by - ay * bx;
			dt = ax * bx + ay * by;
			// half-open crossing with the point to the right of the edge
			if (ay <= 0 && by > 0 && cr < 0)
				parity = !parity;
			// collinear and between the ends
			if (cr == 0 && dt <= 0)
				on_edge = 1'b1;
		endfunction

		function void take_vertex(pip_pkg::field_t vx_f, pip_pkg::field_t vy_f,
				pip_pkg::field_t qx_f, pip_pkg::field_t qy_f, bit is_first, bit is_last);
			pip_pkg::coord_t vx, vy;
			vx = field_coord(vx_f);
			vy = field_coord(vy_f);
			if (is_first) begin
				point_x = field_coord(qx_f);
				point_y = field_coord(qy_f);
				start_x = vx;
				start_y = vy;
				parity  = 1'b0;
				on_edge = 1'b0;
			end else begin
				cross_edge(prev_x, prev_y, vx, vy);
			end
			prev_x = vx;
			prev_y = vy;
			if (is_last) begin
				// closing edge back to the first vertex
				cross_edge(vx, vy, start_x, start_y);
				if (on_edge)
					verdicts_due.push_back(pip_pkg::VERDICT_ON);
				else if (parity)
					verdicts_due.push_back(pip_pkg::VERDICT_IN);
				else
					verdicts_due.push_back(pip_pkg::VERDICT_OUT);
			end
		endfunction

		function void check_verdict(logic [1:0] got);
			logic [1:0] want;
			if (verdicts_due.size() == 0) begin
				$display("%0t: verdict mismatch, expected none, actual %0d", $time, got);
				errors++;
			end else begin
				want = verdicts_due.pop_front();
				if (got !== want) begin
					$display("%0t: verdict mismatch, expected %0d, actual %0d",
						$time, want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	pip_pkg::field_t vertex_x;
	pip_pkg::field_t vertex_y;
	pip_pkg::field_t query_x;
	pip_pkg::field_t query_y;
	logic            first;
	logic            last;
	logic            out_valid;
	logic            out_stall;
	logic [1:0]      verdict;

	crossing_board crossings;
	int unsigned   items_sent;
	// raised by the stimulus to ask the receiver for its one long hold-off
	bit            hold_req;

	point_in_polygon_test i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.vertex_x  (vertex_x),
		.vertex_y  (vertex_y),
		.query_x   (query_x),
		.query_y   (query_y),
		.first     (first),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.verdict   (verdict)
	);

	// 8 ns period
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// coordinate from one of three spreads: tight for boundary hits, mid, full range
	function automatic int pick_coord(int unsigned spread);
		pip_pkg::coord_t c;
		if (spread == 0)
			return int'($urandom_range(0, 32)) - 16;
		else if (spread == 1)
			return int'($urandom_range(0, 2000)) - 1000;
		c = pip_pkg::coord_t'($urandom);
		return int'(c);
	endfunction

	// one vertex item; payload held while stalled, optional idle after acceptance
	task automatic send_vertex(input int x, input int y, input int qx, input int qy,
			input bit f, input bit l, input int unsigned gap);
		vertex_x = pip_pkg::field_t'(x);
		vertex_y = pip_pkg::field_t'(y);
		query_x  = pip_pkg::field_t'(qx);
		query_y  = pip_pkg::field_t'(qy);
		first    = f;
		last     = l;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		crossings.take_vertex(vertex_x, vertex_y, query_x, query_y, first, last);
		items_sent++;
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// well-formed triangle, first on the first vertex and last on the third
	task automatic send_tri(input int x0, input int y0, input int x1, input int y1,
			input int x2, input int y2, input int qx, input int qy);
		send_vertex(x0, y0, qx, qy, 1'b1, 1'b0, idle_len());
		send_vertex(x1, y1, qx, qy, 1'b0, 1'b0, idle_len());
		send_vertex(x2, y2, qx, qy, 1'b0, 1'b1, idle_len());
	endtask

	// random polygon; mostly well formed, sometimes with scrambled first/last marks
	task automatic send_random_polygon(input bit no_gaps);
		int          px[8];
		int          py[8];
		int unsigned n, spread, r, k;
		int          qx, qy;
		bit          noisy, f, l;
		r = $urandom_range(0, 99);
		n = (r < 12) ? $urandom_range(1, 2) : $urandom_range(3, 8);
		r = $urandom_range(0, 99);
		spread = (r < 50) ? 0 : ((r < 75) ? 1 : 2);
		for (int i = 0; i < n; i++) begin
			px[i] = pick_coord(spread);
			py[i] = pick_coord(spread);
		end
		// query at a vertex, near an edge midpoint, or anywhere
		r = $urandom_range(0, 99);
		k = $urandom_range(0, n - 1);
		if (r < 20) begin
			qx = px[k];
			qy = py[k];
		end else if (r < 35) begin
			qx = (px[k] + px[(k + 1) % n]) >>> 1;
			qy = (py[k] + py[(k + 1) % n]) >>> 1;
		end else begin
			qx = pick_coord(spread);
			qy = pick_coord(spread);
		end
		noisy = ($urandom_range(0, 99) < 10);
		for (int i = 0; i < n; i++) begin
			if (noisy) begin
				f = ($urandom_range(0, 3) == 0);
				l = ($urandom_range(0, 3) == 0);
			end else begin
				f = (i == 0);
				l = (i == n - 1);
			end
			// query fields only matter on a first vertex; junk elsewhere
			if (f)
				send_vertex(px[i], py[i], qx, qy, f, l, no_gaps ? 0 : idle_len());
			else
				send_vertex(px[i], py[i], int'($urandom), int'($urandom), f, l,
					no_gaps ? 0 : idle_len());
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int unsigned n;
		bit          held;
		held      = 1'b0;
		out_stall = 1'b0;
		forever begin
			if (hold_req && !held) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
			end
			out_stall = 1'b0;
			// free stretches, now and then long ones with no stall at all
			if ($urandom_range(0, 9) == 0)
				n = $urandom_range(20, 60);
			else
				n = $urandom_range(1, 8);
			for (int i = 0; i < n && !(hold_req && !held); i++)
				@(negedge clk);
			out_stall = 1'b1;
			n = idle_len() + 1;
			for (int i = 0; i < n && !(hold_req && !held); i++)
				@(negedge clk);
		end
	end

	// verdict check at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			crossings.check_verdict(verdict);
	end

	// watchdog: cycles in which no item moves on either side
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("** point_in_polygon_test: FAILED **");
		$finish;
	end

	// stimulus
	initial begin
		bit no_gaps;
		bit hold_done;
		crossings  = new();
		items_sent = 0;
		hold_req   = 1'b0;
		hold_done  = 1'b0;
		no_gaps    = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		vertex_x   = '0;
		vertex_y   = '0;
		query_x    = '0;
		query_y    = '0;
		first      = 1'b0;
		last       = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// vertices with no first since reset: continue from the zero state
		send_vertex(3, 4, 0, 0, 1'b0, 1'b0, 0);
		send_vertex(5, -2, 0, 0, 1'b0, 1'b1, 1);

		// triangle: query inside, on an edge, on a vertex, outside
		send_tri(-10, -10, 10, -10, 0, 10, 0, 0);
		send_tri(-10, -10, 10, -10, 0, 10, 0, -10);
		send_tri(-10, -10, 10, -10, 0, 10, 10, -10);
		send_tri(-10, -10, 10, -10, 0, 10, 20, 20);

		// one-vertex polygons: equal to the query point, then not
		send_vertex(7, -7, 7, -7, 1'b1, 1'b1, 0);
		send_vertex(7, -7, 7, -6, 1'b1, 1'b1, 2);

		// full-range triangle: largest differences and products
		send_tri(-32768, -32768, 32767, -32768, 0, 32767, 0, 0);
		send_tri(-32768, -32768, 32767, -32768, 0, 32767, -32768, 32767);

		// last again with no new first: flags carry over from the held state
		send_vertex(32767, 32767, -1, -1, 1'b0, 1'b1, 0);

		// random part, with one receiver hold-off halfway through
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 15)
				no_gaps = !no_gaps;
			if (!hold_done && items_sent > RANDOM_ITEMS / 2) begin
				// fill the block against a stalled receiver, then drain fully
				hold_done = 1'b1;
				hold_req  = 1'b1;
				for (int i = 0; i < 20; i++)
					send_random_polygon(1'b1);
				in_valid = 1'b0;
				while (crossings.pending() != 0)
					@(negedge clk);
			end
			send_random_polygon(no_gaps);
		end
		in_valid = 1'b0;

		// drain: every verdict in, then wait DRAIN_CYCLES for stray results
		while (crossings.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (crossings.errors == 0 && crossings.pending() == 0)
			$display("** point_in_polygon_test: PASSED **");
		else
			$display("** point_in_polygon_test: FAILED **");
		$finish;
	end

endmodule
